// ===== hdl/mcc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, method codes and code functions for the message check-code checker.
// No dependencies; used by mcc_accum, mcc_select and the top level.
package mcc_pkg;

	localparam int unsigned DataW  = 8;
	localparam int unsigned CheckW = 16;
	localparam int unsigned MethW  = 3;
	localparam int unsigned HamW   = 3;

	localparam logic [CheckW-1:0] CrcInit = 16'hFFFF;

	typedef enum logic [MethW-1:0] {
		METH_NONE     = 3'd0,
		METH_PARITY   = 3'd1,
		METH_XOR      = 3'd2,
		METH_CRC16    = 3'd3,
		METH_HAMMING  = 3'd4,
		METH_CHECKSUM = 3'd5
	} method_t;

	// All codes of a message, as they stand after the current beat.
	typedef struct packed {
		logic              parity;
		logic [DataW-1:0]  xor_code;
		logic [CheckW-1:0] crc;
		logic [DataW-1:0]  sum;
		logic [HamW-1:0]   ham;
	} codes_t;

	// One byte of CRC-16/CCITT-FALSE, polynomial 0x1021, MSB first.
	function automatic logic [CheckW-1:0] crc_update(input logic [CheckW-1:0] crc,
			input logic [DataW-1:0] b);
		logic [DataW-1:0] x;
		x = crc[15:8] ^ b;
		x = x ^ {4'd0, x[7:4]};
		crc_update = {crc[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
	endfunction

	// Hamming(7,4) parity bits of the low nibble, laid out p4,p2,p1.
	function automatic logic [HamW-1:0] hamming_of(input logic [DataW-1:0] v);
		hamming_of = {v[1] ^ v[2] ^ v[3], v[0] ^ v[2] ^ v[3], v[0] ^ v[1] ^ v[3]};
	endfunction

endpackage

// ===== hdl/mcc_accum.sv =====
`timescale 1ns / 1ps
// Running code accumulators: parity, XOR, CRC-16, sum and first-byte Hamming bits.
// Depends on mcc_pkg.
module mcc_accum (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic                      last,
	input  logic [mcc_pkg::DataW-1:0] data_byte,
	output mcc_pkg::codes_t           codes
);
	import mcc_pkg::*;

	logic              parity_q;
	logic [DataW-1:0]  xor_q;
	logic [CheckW-1:0] crc_q;
	logic [DataW-1:0]  sum_q;
	logic [HamW-1:0]   ham_q;
	logic              first_q;

	always_comb begin
		codes.parity   = parity_q ^ (^data_byte);
		codes.xor_code = xor_q ^ data_byte;
		codes.crc      = crc_update(crc_q, data_byte);
		codes.sum      = sum_q + data_byte;
		codes.ham      = first_q ? hamming_of(data_byte) : ham_q;
	end

	// The last beat of a message hands its codes on and starts the next message clean.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
			xor_q    <= '0;
			crc_q    <= CrcInit;
			sum_q    <= '0;
			ham_q    <= '0;
			first_q  <= 1'b1;
		end else if (advance) begin
			if (last) begin
				parity_q <= 1'b0;
				xor_q    <= '0;
				crc_q    <= CrcInit;
				sum_q    <= '0;
				ham_q    <= '0;
				first_q  <= 1'b1;
			end else begin
				parity_q <= codes.parity;
				xor_q    <= codes.xor_code;
				crc_q    <= codes.crc;
				sum_q    <= codes.sum;
				ham_q    <= codes.ham;
				first_q  <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/mcc_select.sv =====
`timescale 1ns / 1ps
// Picks the code named by the method and compares it with the received check value.
// Depends on mcc_pkg.
module mcc_select (
	input  mcc_pkg::codes_t            codes,
	input  logic [mcc_pkg::MethW-1:0]  method,
	input  logic [mcc_pkg::CheckW-1:0] received_check,
	output logic [mcc_pkg::CheckW-1:0] computed_check,
	output logic                       match
);
	import mcc_pkg::*;

	always_comb begin
		case (method_t'(method))
			METH_PARITY:   computed_check = {{(CheckW-1){1'b0}}, codes.parity};
			METH_XOR:      computed_check = {{(CheckW-DataW){1'b0}}, codes.xor_code};
			METH_CRC16:    computed_check = codes.crc;
			METH_HAMMING:  computed_check = {{(CheckW-HamW){1'b0}}, codes.ham};
			METH_CHECKSUM: computed_check = {{(CheckW-DataW){1'b0}}, codes.sum};
			default:       computed_check = '0;
		endcase
		match = (computed_check == received_check);
	end

endmodule

// ===== hdl/multi_code_message_checker_top.sv =====
`timescale 1ns / 1ps
// Top level of the message check-code checker: input register, accumulators, result register.
// Depends on mcc_pkg, mcc_accum and mcc_select.

// The block takes a message one byte per beat and accepts a new beat every clock cycle
// while no last beat waits. A beat sits in the input register, where the running parity,
// XOR, CRC-16/CCITT-FALSE, sum and first-byte Hamming bits are updated in a single pass;
// on the beat marked tlast the code chosen by the method in s_tuser and its match flag
// pass from the input register into the result register. The result register holds
// a result while the sink stalls; non-last beats keep flowing meanwhile, and only a
// last beat waits behind an untaken result. Bytes are unsigned and framing comes from
// tlast alone; unknown methods give a code of zero.
module multi_code_message_checker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // data_byte[7:0], received_check[23:8]
	input  logic        s_tlast,
	input  logic [2:0]  s_tuser,   // method[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // computed_check[15:0]
	output logic        m_tuser    // match[0]
);
	import mcc_pkg::*;

	logic              valid_s1;
	logic [DataW-1:0]  data_s1;
	logic              last_s1;
	logic [MethW-1:0]  method_s1;
	logic [CheckW-1:0] rcv_s1;

	logic              valid_s2;
	logic [CheckW-1:0] check_s2;
	logic              match_s2;

	logic              out_free;
	logic              consume_s1;
	logic              s_accept;
	codes_t            codes;
	logic [CheckW-1:0] check_nxt;
	logic              match_nxt;

	assign out_free   = !valid_s2 || m_tready;
	assign consume_s1 = valid_s1 && (!last_s1 || out_free);
	assign s_tready   = !valid_s1 || consume_s1;
	assign s_accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (consume_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			data_s1   <= s_tdata[7:0];
			rcv_s1    <= s_tdata[23:8];
			last_s1   <= s_tlast;
			method_s1 <= s_tuser;
		end
	end

	mcc_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (consume_s1),
		.last      (last_s1),
		.data_byte (data_s1),
		.codes     (codes)
	);

	mcc_select u_select (
		.codes          (codes),
		.method         (method_s1),
		.received_check (rcv_s1),
		.computed_check (check_nxt),
		.match          (match_nxt)
	);

	// A last beat is consumed only when the result register is free or being emptied.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (consume_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume_s1 && last_s1) begin
			check_s2 <= check_nxt;
			match_s2 <= match_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = check_s2;
	assign m_tuser  = match_s2;

endmodule

// ===== hdl/mcc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the message check-code checker, bound to the top level.
// Depends only on the ports of multi_code_message_checker_top.
module mcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	logic       last_in;
	logic       res_out;
	logic [1:0] pending_q;

	assign last_in = s_tvalid && s_tready && s_tlast;
	assign res_out = m_tvalid && m_tready;

	// Messages whose last beat went in but whose result has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (last_in && !res_out) begin
			pending_q <= pending_q + 2'd1;
		end else if (res_out && !last_in) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_result_has_message: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 2'd0)
		else $error("result beat without a finished message");

	a_pending_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more finished messages in flight than the pipeline holds");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty result register");

endmodule

bind multi_code_message_checker_top mcc_checker u_mcc_checker (.*);
